@@ sv/vtr_pkg.sv @@
package vtr_pkg;

    // Default geometry and parser depth
    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;
    localparam int DEF_PARAM_SLOTS    = 8;

    // Payload widths of the channels
    localparam int FUNC_W  = 1;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int ATTR_W  = 8;
    localparam int PARAM_W = 16;

    // Item functions
    localparam logic FUNC_FEED = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Character codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] FINAL_LO  = 8'h40;
    localparam logic [7:0] FINAL_HI  = 8'h7E;
    localparam logic [7:0] FIN_ED    = 8'h4A;  // J
    localparam logic [7:0] FIN_CUP   = 8'h48;  // H
    localparam logic [7:0] FIN_RESET = 8'h6C;  // l
    localparam logic [7:0] FIN_SET   = 8'h68;  // h
    localparam logic [7:0] FIN_SGR   = 8'h6D;  // m

    // Parameter values with a meaning
    localparam logic [15:0] ED_ALL        = 16'd2;
    localparam logic [15:0] SGR_UNDERLINE = 16'd4;
    localparam logic [15:0] SGR_REVERSE   = 16'd7;
    localparam logic [15:0] PRIV_CURSOR   = 16'd25;
    localparam logic [15:0] PARAM_MAX     = 16'hFFFF;

    localparam logic [7:0] ATTR_REVERSE   = 8'h80;
    localparam logic [7:0] ATTR_UNDERLINE = 8'h20;

    localparam logic [7:0]  GLYPH_OFFSET_RESET = 8'd100;
    localparam logic [15:0] BLANK_RESET = {8'h00, CH_SPACE} + {8'h00, GLYPH_OFFSET_RESET};

    // Memory work that a byte asks of the cell store
    typedef struct packed {
        logic       write;
        logic       clear;
        logic       scroll;
        logic [7:0] glyph_byte;
    } vtr_cmd_t;

    // Attribute before and after the step, and cursor visibility after it
    typedef struct packed {
        logic [7:0] cur_attribute;
        logic [7:0] next_attribute;
        logic       next_hidden;
    } vtr_status_t;

endpackage

@@ sv/vtr_if.sv @@
interface vtr_item_if;
    import vtr_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, output func, output data_byte, output cell_address,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input cell_address,
                    output ready);
endinterface

interface vtr_result_if;
    import vtr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_data;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 cursor_off;
    logic [ATTR_W-1:0]    current_attribute;

    modport source (output valid, output cell_data, output cursor_col, output cursor_row,
                    output cursor_off, output current_attribute, input ready);
    modport sink   (input valid, input cell_data, input cursor_col, input cursor_row,
                    input cursor_off, input current_attribute, output ready);
endinterface

@@ sv/vtr_parser.sv @@
module vtr_parser #(
    parameter int SCREEN_COLUMNS = vtr_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = vtr_pkg::DEF_SCREEN_ROWS,
    parameter int PARAM_SLOTS    = vtr_pkg::DEF_PARAM_SLOTS,
    localparam int COL_W  = $clog2(SCREEN_COLUMNS),
    localparam int ROW_W  = $clog2(SCREEN_ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 feed,
    input  logic [7:0]           data_byte,
    output vtr_pkg::vtr_cmd_t    cmd,
    output vtr_pkg::vtr_status_t status,
    output logic [COL_W-1:0]     cur_col,
    output logic [ROW_W-1:0]     cur_row,
    output logic [COL_W-1:0]     next_col,
    output logic [ROW_W-1:0]     next_row
);
    import vtr_pkg::*;

    localparam int SLOT_W = $clog2(PARAM_SLOTS);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    logic [1:0]        mode_reg, mode_next;
    logic              private_reg, private_next;
    logic              any_param_reg, any_param_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [15:0]       param_reg [PARAM_SLOTS];
    logic [15:0]       param_next [PARAM_SLOTS];
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        attr_reg, attr_next;
    logic              hidden_reg, hidden_next;

    logic [19:0]       acc;
    logic [15:0]       dec_row, dec_col;
    logic [7:0]        sgr;
    logic [SLOT_W-1:0] semi_slot;

    always_comb
    begin
        mode_next      = mode_reg;
        private_next   = private_reg;
        any_param_next = any_param_reg;
        slot_next      = slot_reg;
        param_next     = param_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = attr_reg;
        hidden_next    = hidden_reg;
        cmd            = '0;
        cmd.glyph_byte = data_byte;

        acc = {4'h0, param_reg[slot_reg]} * 20'd10 + 20'(4'(data_byte - CH_ZERO));
        dec_row = param_reg[0] - 16'd1;
        dec_col = param_reg[1] - 16'd1;
        semi_slot = (slot_reg < SLOT_W'(PARAM_SLOTS - 1)) ? slot_reg + SLOT_W'(1) : slot_reg;
        sgr = '0;
        for (int i = 0; i < PARAM_SLOTS; i++)
        begin
            if (SLOT_W'(i) <= slot_reg)
            begin
                if (param_reg[i] == SGR_REVERSE)
                    sgr = sgr | ATTR_REVERSE;
                if (param_reg[i] == SGR_UNDERLINE)
                    sgr = sgr | ATTR_UNDERLINE;
            end
        end

        if (feed)
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (data_byte == CH_ESC)
                        mode_next = MODE_ESC;
                    else if (data_byte == CH_CR)
                        col_next = '0;
                    else if (data_byte == CH_LF)
                    begin
                        if (row_reg < ROW_W'(SCREEN_ROWS - 1))
                            row_next = row_reg + ROW_W'(1);
                        else
                            cmd.scroll = 1'b1;
                    end
                    else if (data_byte == CH_BS)
                    begin
                        if (col_reg != '0)
                            col_next = col_reg - COL_W'(1);
                    end
                    else if (data_byte >= CH_SPACE)
                    begin
                        cmd.write = 1'b1;
                        if (col_reg < COL_W'(SCREEN_COLUMNS - 1))
                            col_next = col_reg + COL_W'(1);
                    end
                end
                MODE_ESC:
                begin
                    if (data_byte == CH_LBRACK)
                    begin
                        mode_next      = MODE_CSI;
                        private_next   = 1'b0;
                        any_param_next = 1'b0;
                        slot_next      = '0;
                        for (int i = 0; i < PARAM_SLOTS; i++)
                            param_next[i] = '0;
                    end
                    else
                        mode_next = MODE_NORMAL;
                end
                MODE_CSI:
                begin
                    if (data_byte inside {[FINAL_LO:FINAL_HI]})
                    begin
                        mode_next = MODE_NORMAL;
                        case (data_byte)
                            FIN_ED:
                            begin
                                if (param_reg[0] == ED_ALL)
                                begin
                                    cmd.clear = 1'b1;
                                    col_next  = '0;
                                    row_next  = '0;
                                end
                            end
                            FIN_CUP:
                            begin
                                if (!any_param_reg || (slot_reg == '0 && param_reg[0] == '0))
                                begin
                                    col_next = '0;
                                    row_next = '0;
                                end
                                else
                                begin
                                    if (param_reg[0] == '0)
                                        row_next = '0;
                                    else if (param_reg[0] > 16'(SCREEN_ROWS))
                                        row_next = ROW_W'(SCREEN_ROWS - 1);
                                    else
                                        row_next = dec_row[ROW_W-1:0];
                                    if (param_reg[1] == '0)
                                        col_next = '0;
                                    else if (param_reg[1] > 16'(SCREEN_COLUMNS))
                                        col_next = COL_W'(SCREEN_COLUMNS - 1);
                                    else
                                        col_next = dec_col[COL_W-1:0];
                                end
                            end
                            FIN_RESET:
                            begin
                                if (private_reg && param_reg[0] == PRIV_CURSOR)
                                    hidden_next = 1'b1;
                            end
                            FIN_SET:
                            begin
                                if (private_reg && param_reg[0] == PRIV_CURSOR)
                                    hidden_next = 1'b0;
                            end
                            FIN_SGR:
                                attr_next = sgr;
                            default:
                                ;
                        endcase
                    end
                    else if (data_byte inside {[CH_ZERO:CH_NINE]})
                    begin
                        param_next[slot_reg] = (acc > 20'(PARAM_MAX)) ? PARAM_MAX : acc[15:0];
                        any_param_next = 1'b1;
                    end
                    else if (data_byte == CH_SEMI)
                    begin
                        slot_next = semi_slot;
                        param_next[semi_slot] = '0;
                        any_param_next = 1'b1;
                    end
                    else if (data_byte == CH_QMARK)
                        private_next = 1'b1;
                end
                default:
                    mode_next = MODE_NORMAL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            private_reg   <= 1'b0;
            any_param_reg <= 1'b0;
            slot_reg      <= '0;
            for (int i = 0; i < PARAM_SLOTS; i++)
                param_reg[i] <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= '0;
            hidden_reg    <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            private_reg   <= private_next;
            any_param_reg <= any_param_next;
            slot_reg      <= slot_next;
            param_reg     <= param_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            hidden_reg    <= hidden_next;
        end
    end

    assign cur_col  = col_reg;
    assign cur_row  = row_reg;
    assign next_col = col_next;
    assign next_row = row_next;
    assign status.cur_attribute  = attr_reg;
    assign status.next_attribute = attr_next;
    assign status.next_hidden    = hidden_next;

endmodule

@@ sv/vt100_text_screen_renderer.sv @@
// A plain byte's word is registered into the output stage on acceptance; a read first
// waits in S_READ for its data. ED 2 (clear) sweeps every cell, a scrolling LF copies each
// row up and blanks the bottom row; both are bound by the cell store's single write port.
// One plain byte a cycle while the skid is empty; a read takes no new item until its word
// is done. A two-deep output stage lets the next item in while the previous word waits.
// Reset clears control state, then sweeps the store with blank cells, items held.
module vt100_text_screen_renderer #(
    parameter int SCREEN_COLUMNS = vtr_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = vtr_pkg::DEF_SCREEN_ROWS,
    parameter int PARAM_SLOTS    = vtr_pkg::DEF_PARAM_SLOTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    vtr_item_if.sink     item,
    vtr_result_if.source result
);
    import vtr_pkg::*;

    localparam int CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int COL_W   = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W   = $clog2(SCREEN_ROWS);
    localparam int ADDR_CMP_W = (CELL_AW > ADDR_W) ? CELL_AW : ADDR_W;

    localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] COPY_END  = CELL_AW'(CELLS - SCREEN_COLUMNS);

    // Sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;  // blank sweep after reset
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;  // registered read data is back
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;  // copy each row up by one
    localparam logic [2:0] S_BLANK  = 3'd5;  // blank the bottom row

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic                 cursor_off;
        logic [ATTR_W-1:0]    current_attribute;
    } word_t;

    // Cell store: one write and one registered read per cycle
    logic [CELL_W-1:0]  screen_mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_AW-1:0] mem_raddr;

    logic [2:0]         state_reg, state_next;
    logic [CELL_AW-1:0] sweep_reg, sweep_next;
    logic [CELL_AW-1:0] dst_reg, dst_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               addr_ok_reg, addr_ok_next;
    logic [7:0]         offset_reg;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    word_t              out_reg, skid_reg, word;
    logic               load_out, load_skid, out_from_skid;

    logic               accept, feed, take, done;
    logic [ADDR_CMP_W-1:0] addr_wide;
    logic               addr_ok;
    logic [CELL_AW-1:0] item_idx;
    logic [CELL_AW-1:0] cur_pos;
    logic [CELL_W-1:0]  glyph_cell, blank_glyph;

    vtr_cmd_t           cmd;
    vtr_status_t        status;
    logic [COL_W-1:0]   cur_col, next_col;
    logic [ROW_W-1:0]   cur_row, next_row;

    assign item.ready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign accept     = item.valid && item.ready;
    assign feed       = accept && (item.func == FUNC_FEED);
    assign take       = out_valid_reg && result.ready;

    vtr_parser #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .PARAM_SLOTS    (PARAM_SLOTS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed),
        .data_byte (item.data_byte),
        .cmd       (cmd),
        .status    (status),
        .cur_col   (cur_col),
        .cur_row   (cur_row),
        .next_col  (next_col),
        .next_row  (next_row)
    );

    // Addresses beyond the screen read as zero
    assign addr_wide = ADDR_CMP_W'(item.cell_address);
    assign addr_ok   = addr_wide < ADDR_CMP_W'(CELLS);
    assign item_idx  = addr_wide[CELL_AW-1:0];

    assign cur_pos    = CELL_AW'(cur_row) * CELL_AW'(SCREEN_COLUMNS) + CELL_AW'(cur_col);
    // The glyph sum may carry into bit 8; it is ORed with the attribute, not kept apart
    assign glyph_cell = ({8'h00, cmd.glyph_byte} + {8'h00, offset_reg})
                        | {status.cur_attribute, 8'h00};
    assign blank_glyph = {8'h00, CH_SPACE} + {8'h00, offset_reg};

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        dst_next     = dst_reg;
        rd_pend_next = 1'b0;
        addr_ok_next = addr_ok_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_pos;
        mem_wdata    = glyph_cell;
        mem_raddr    = item_idx;
        done         = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Reset blank uses the reset offset, whatever is written meanwhile
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = BLANK_RESET;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                    sweep_next = '0;
                end
                else
                    sweep_next = sweep_reg + CELL_AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_READ)
                    begin
                        addr_ok_next = addr_ok;
                        state_next   = S_READ;
                    end
                    else if (cmd.clear)
                    begin
                        state_next = S_CLEAR;
                        sweep_next = '0;
                    end
                    else if (cmd.scroll)
                    begin
                        state_next = S_SCROLL;
                        sweep_next = '0;
                    end
                    else
                    begin
                        mem_we = cmd.write;
                        done   = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = blank_glyph;
                if (sweep_reg == LAST_CELL)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    sweep_next = '0;
                end
                else
                    sweep_next = sweep_reg + CELL_AW'(1);
            end
            S_SCROLL:
            begin
                // Read one row ahead, write back the cell fetched last cycle
                mem_raddr = sweep_reg + CELL_AW'(SCREEN_COLUMNS);
                if (rd_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rd_data_reg;
                end
                if (sweep_reg == COPY_END)
                    state_next = S_BLANK;
                else
                begin
                    rd_pend_next = 1'b1;
                    dst_next     = sweep_reg;
                    sweep_next   = sweep_reg + CELL_AW'(1);
                end
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = blank_glyph;
                if (sweep_reg == LAST_CELL)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                    sweep_next = '0;
                end
                else
                    sweep_next = sweep_reg + CELL_AW'(1);
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= screen_mem[mem_raddr];
    end

    // Word as seen after the step; later states see the parser already settled
    always_comb
    begin
        word.cell_data         = (state_reg == S_READ && addr_ok_reg) ? rd_data_reg : '0;
        word.cursor_col        = COL_OUT_W'(next_col);
        word.cursor_row        = ROW_OUT_W'(next_row);
        word.cursor_off        = status.next_hidden;
        word.current_attribute = status.next_attribute;
    end

    // Two-deep output: skid holds a word while the output register is stalled
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
        if (done)
        begin
            if (!out_valid_reg || (take && !skid_valid_reg))
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            sweep_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            offset_reg     <= GLYPH_OFFSET_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_we)
                offset_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg     <= dst_next;
        addr_ok_reg <= addr_ok_next;
        if (load_out)
            out_reg <= word;
        else if (out_from_skid)
            out_reg <= skid_reg;
        if (load_skid)
            skid_reg <= word;
    end

    assign result.valid             = out_valid_reg;
    assign result.cell_data         = out_reg.cell_data;
    assign result.cursor_col        = out_reg.cursor_col;
    assign result.cursor_row        = out_reg.cursor_row;
    assign result.cursor_off        = out_reg.cursor_off;
    assign result.current_attribute = out_reg.current_attribute;

`ifndef SYNTHESIS
    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == FUNC_READ) |=> (state_reg == S_READ))
        else $error("read item did not move to the read state");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_done_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !skid_valid_reg)
        else $error("word completed with both output stages full");

    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && rd_pend_reg) |-> (CELL_AW'(dst_reg + 1'b1) == sweep_reg))
        else $error("scroll write does not trail its read");
`endif

endmodule
